// ===== design/cfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfu_pkg
// Shared codes and item types of the control-flow execute unit.
// ----------------------------------------------------------------------------
package cfu_pkg;

    // function codes
    localparam logic [3:0] FN_HALT    = 4'd0;
    localparam logic [3:0] FN_STOP    = 4'd1;
    localparam logic [3:0] FN_JP_HL   = 4'd2;
    localparam logic [3:0] FN_JP_NN   = 4'd3;
    localparam logic [3:0] FN_JR_N    = 4'd4;
    localparam logic [3:0] FN_SCF     = 4'd5;
    localparam logic [3:0] FN_CCF     = 4'd6;
    localparam logic [3:0] FN_DI      = 4'd7;
    localparam logic [3:0] FN_EI      = 4'd8;
    localparam logic [3:0] FN_RET     = 4'd9;
    localparam logic [3:0] FN_RET_CC  = 4'd10;
    localparam logic [3:0] FN_RETI    = 4'd11;
    localparam logic [3:0] FN_CALL_NN = 4'd12;

    // condition codes
    localparam logic [2:0] CC_ALWAYS = 3'd0;
    localparam logic [2:0] CC_NZ     = 3'd1;
    localparam logic [2:0] CC_NC     = 3'd2;
    localparam logic [2:0] CC_Z      = 3'd3;
    localparam logic [2:0] CC_C      = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_WAIT     = 2'd1;
    localparam logic [1:0] ST_HALT_IME = 2'd2;
    localparam logic [1:0] ST_STOPPED  = 2'd3;

    typedef struct packed {
        logic [3:0]  func;
        logic [2:0]  cond;
        logic        flag_zero;
        logic        flag_carry;
        logic [15:0] pc_in;
        logic [15:0] sp_in;
        logic [15:0] hl_value;
        logic [7:0]  imm_low;
        logic [7:0]  imm_high;
        logic [7:0]  stack_low;
        logic [7:0]  stack_high;
        logic        irq_pending;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        taken;
        logic [15:0] pc_out;
        logic [15:0] sp_out;
        logic        ime_out;
        logic        carry_out;
        logic        push_valid;
        logic [7:0]  push_high;
        logic [7:0]  push_low;
        logic [2:0]  m_cycles;
    } t_result;

    typedef struct packed {
        logic ime;
        logic halt_wait;
    } t_state;

endpackage

// ===== design/cfu_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfu_exec
// Single-pass execute logic: result and next state for one instruction.
// ----------------------------------------------------------------------------
module cfu_exec (
    input  cfu_pkg::t_item   i_item,
    input  cfu_pkg::t_state  i_state,
    output cfu_pkg::t_result o_result,
    output cfu_pkg::t_state  o_state
);
    import cfu_pkg::*;

    logic        cond_ok;
    logic [15:0] imm16;
    logic [15:0] stk16;
    logic [15:0] ret_addr;
    logic [15:0] rel_off;

    assign imm16    = {i_item.imm_high, i_item.imm_low};
    assign stk16    = {i_item.stack_high, i_item.stack_low};
    assign ret_addr = i_item.pc_in + 16'd3;
    assign rel_off  = {{8{i_item.imm_low[7]}}, i_item.imm_low};

    always_comb begin
        unique case (i_item.cond)
            CC_ALWAYS: cond_ok = 1'b1;
            CC_NZ:     cond_ok = ~i_item.flag_zero;
            CC_NC:     cond_ok = ~i_item.flag_carry;
            CC_Z:      cond_ok = i_item.flag_zero;
            CC_C:      cond_ok = i_item.flag_carry;
            default:   cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_result.status     = ST_DONE;
        o_result.taken      = 1'b0;
        o_result.pc_out     = i_item.pc_in + 16'd1;
        o_result.sp_out     = i_item.sp_in;
        o_result.carry_out  = i_item.flag_carry;
        o_result.push_valid = 1'b0;
        o_result.push_high  = 8'd0;
        o_result.push_low   = 8'd0;
        o_result.m_cycles   = 3'd1;
        o_state.ime         = i_state.ime;
        o_state.halt_wait   = 1'b0;

        unique case (i_item.func) inside
            FN_HALT: begin
                if (i_state.ime) begin
                    o_result.status = ST_HALT_IME;
                end else if (!(i_state.halt_wait && i_item.irq_pending)) begin
                    // keep polling until an interrupt shows up on a later pass
                    o_result.status   = ST_WAIT;
                    o_result.pc_out   = i_item.pc_in;
                    o_state.halt_wait = 1'b1;
                end
            end
            FN_STOP: o_result.status = ST_STOPPED;
            FN_JP_HL: begin
                o_result.pc_out = i_item.hl_value;
                o_result.taken  = 1'b1;
            end
            FN_JP_NN: begin
                if (cond_ok) begin
                    o_result.pc_out   = imm16;
                    o_result.taken    = 1'b1;
                    o_result.m_cycles = 3'd4;
                end else begin
                    o_result.pc_out   = ret_addr;
                    o_result.m_cycles = 3'd3;
                end
            end
            FN_JR_N: begin
                if (cond_ok) begin
                    o_result.pc_out   = i_item.pc_in + 16'd2 + rel_off;
                    o_result.taken    = 1'b1;
                    o_result.m_cycles = 3'd3;
                end else begin
                    o_result.pc_out   = i_item.pc_in + 16'd2;
                    o_result.m_cycles = 3'd2;
                end
            end
            FN_SCF: o_result.carry_out = 1'b1;
            FN_CCF: o_result.carry_out = ~i_item.flag_carry;
            FN_DI:  o_state.ime = 1'b0;
            FN_EI:  o_state.ime = 1'b1;
            FN_RET, FN_RETI: begin
                o_result.pc_out   = stk16;
                o_result.sp_out   = i_item.sp_in + 16'd2;
                o_result.taken    = 1'b1;
                o_result.m_cycles = 3'd4;
                if (i_item.func == FN_RETI) begin
                    o_state.ime = 1'b1;
                end
            end
            FN_RET_CC: begin
                if (cond_ok) begin
                    o_result.pc_out   = stk16;
                    o_result.sp_out   = i_item.sp_in + 16'd2;
                    o_result.taken    = 1'b1;
                    o_result.m_cycles = 3'd5;
                end else begin
                    o_result.m_cycles = 3'd2;
                end
            end
            FN_CALL_NN: begin
                if (cond_ok) begin
                    o_result.push_valid = 1'b1;
                    o_result.push_high  = ret_addr[15:8];
                    o_result.push_low   = ret_addr[7:0];
                    o_result.sp_out     = i_item.sp_in - 16'd2;
                    o_result.pc_out     = imm16;
                    o_result.taken      = 1'b1;
                    o_result.m_cycles   = 3'd6;
                end else begin
                    o_result.pc_out   = ret_addr;
                    o_result.m_cycles = 3'd3;
                end
            end
            // unused function codes act as one-byte no-ops
            default: ;
        endcase

        o_result.ime_out = o_state.ime;
    end

endmodule

// ===== design/cpu_control_flow_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_control_flow_unit
// Execute unit for control-flow and flag-control instructions.
// ----------------------------------------------------------------------------
// One decoded instruction enters on the input channel (i_in_valid, o_in_stall)
// with its operands, flags and popped stack bytes; one result request leaves
// on the output channel (o_out_valid, i_out_stall) with new PC/SP, push bytes,
// IME, carry, status and M-cycle count.
// Pipeline: input register, single-pass execute logic, result register.
// An accepted instruction passes from the input register into the result register,
// which raises o_out_valid; throughput is one instruction per cycle while the
// receiver does not stall, since IME and the halt wait flag are updated as an
// instruction moves from the input register into the result register.
// When the receiver stalls, the result register holds; the input register
// still takes one more instruction, and o_in_stall rises only once both
// registers are full.
// Reset clears both valid flags, IME and the halt wait flag; o_in_stall is
// held high during reset, so no instruction is accepted.
// ----------------------------------------------------------------------------
module cpu_control_flow_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_func,
    input  logic [2:0]  i_cond,
    input  logic        i_flag_zero,
    input  logic        i_flag_carry,
    input  logic [15:0] i_pc_in,
    input  logic [15:0] i_sp_in,
    input  logic [15:0] i_hl_value,
    input  logic [7:0]  i_imm_low,
    input  logic [7:0]  i_imm_high,
    input  logic [7:0]  i_stack_low,
    input  logic [7:0]  i_stack_high,
    input  logic        i_irq_pending,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_taken,
    output logic [15:0] o_pc_out,
    output logic [15:0] o_sp_out,
    output logic        o_ime_out,
    output logic        o_carry_out,
    output logic        o_push_valid,
    output logic [7:0]  o_push_high,
    output logic [7:0]  o_push_low,
    output logic [2:0]  o_m_cycles
);
    import cfu_pkg::*;

    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;

    t_result n_out;
    t_state  n_state;
    logic    out_free;
    logic    s1_move;
    logic    in_take;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign s1_move  = r_s1_valid & out_free;
    assign in_take  = i_in_valid & ~o_in_stall;

    assign o_in_stall = ~i_rst_n | (r_s1_valid & ~out_free);

    cfu_exec u_exec (
        .i_item   (r_s1_item),
        .i_state  (r_state),
        .o_result (n_out),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.func        <= i_func;
            r_s1_item.cond        <= i_cond;
            r_s1_item.flag_zero   <= i_flag_zero;
            r_s1_item.flag_carry  <= i_flag_carry;
            r_s1_item.pc_in       <= i_pc_in;
            r_s1_item.sp_in       <= i_sp_in;
            r_s1_item.hl_value    <= i_hl_value;
            r_s1_item.imm_low     <= i_imm_low;
            r_s1_item.imm_high    <= i_imm_high;
            r_s1_item.stack_low   <= i_stack_low;
            r_s1_item.stack_high  <= i_stack_high;
            r_s1_item.irq_pending <= i_irq_pending;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_taken      = r_out.taken;
    assign o_pc_out     = r_out.pc_out;
    assign o_sp_out     = r_out.sp_out;
    assign o_ime_out    = r_out.ime_out;
    assign o_carry_out  = r_out.carry_out;
    assign o_push_valid = r_out.push_valid;
    assign o_push_high  = r_out.push_high;
    assign o_push_low   = r_out.push_low;
    assign o_m_cycles   = r_out.m_cycles;

    // the halt wait flag is only ever set while interrupts are disabled
    a_wait_no_ime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halt_wait |-> !r_state.ime)
        else $error("halt wait flag set with IME on");

    a_halt_ime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_HALT_IME) |-> o_ime_out)
        else $error("halted-with-IME status without IME");

    a_push_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_push_valid) |-> (o_taken && o_m_cycles == 3'd6))
        else $error("push request outside a taken call");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    a_ime_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_ime_out == r_state.ime))
        else $error("reported IME differs from held IME");

endmodule

// ===== verif/cfu_flow_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfu_flow_checker
// Watches both channels of the control-flow unit. Every accepted request
// is run through a local model of the branch, stack and halt logic that
// keeps its own IME and halt wait flag. Every accepted result is compared
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cfu_flow_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  cfu_pkg::t_item   i_req,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  cfu_pkg::t_result i_rsp,
    output int               o_fail_count,
    output int               o_pending
);
    import cfu_pkg::*;

    logic    ime_flag;
    logic    halt_armed;
    t_result predicted_q[$];
    int      fail_count = 0;
    int      rsp_idx = 0;

    assign o_fail_count = fail_count;

    task automatic report(string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got_v, logic [15:0] want_v);
        if (got_v !== want_v) begin
            report($sformatf("result %0d %s got %0h want %0h", rsp_idx, name, got_v, want_v));
        end
    endtask

    // updates ime_flag and halt_armed as the block does
    function automatic t_result exec_control_flow(t_item it);
        t_result     r;
        logic        cc_ok;
        logic [15:0] imm16;
        logic [15:0] stk16;
        logic [15:0] ret_addr;
        imm16    = {it.imm_high, it.imm_low};
        stk16    = {it.stack_high, it.stack_low};
        ret_addr = it.pc_in + 16'd3;
        r           = '0;
        r.status    = ST_DONE;
        r.pc_out    = it.pc_in + 16'd1;
        r.sp_out    = it.sp_in;
        r.carry_out = it.flag_carry;
        r.m_cycles  = 3'd1;
        case (it.cond)
            CC_ALWAYS: cc_ok = 1'b1;
            CC_NZ:     cc_ok = !it.flag_zero;
            CC_NC:     cc_ok = !it.flag_carry;
            CC_Z:      cc_ok = it.flag_zero;
            CC_C:      cc_ok = it.flag_carry;
            default:   cc_ok = 1'b0;
        endcase
        if (it.func != FN_HALT) halt_armed = 1'b0;
        case (it.func)
            FN_HALT: begin
                if (ime_flag) begin
                    r.status   = ST_HALT_IME;
                    halt_armed = 1'b0;
                end else if (halt_armed && it.irq_pending) begin
                    halt_armed = 1'b0;
                end else begin
                    r.status   = ST_WAIT;
                    r.pc_out   = it.pc_in;
                    halt_armed = 1'b1;
                end
            end
            FN_STOP: r.status = ST_STOPPED;
            FN_JP_HL: begin
                r.pc_out = it.hl_value;
                r.taken  = 1'b1;
            end
            FN_JP_NN: begin
                if (cc_ok) begin
                    r.pc_out   = imm16;
                    r.taken    = 1'b1;
                    r.m_cycles = 3'd4;
                end else begin
                    r.pc_out   = it.pc_in + 16'd3;
                    r.m_cycles = 3'd3;
                end
            end
            FN_JR_N: begin
                if (cc_ok) begin
                    r.pc_out   = it.pc_in + 16'd2 + {{8{it.imm_low[7]}}, it.imm_low};
                    r.taken    = 1'b1;
                    r.m_cycles = 3'd3;
                end else begin
                    r.pc_out   = it.pc_in + 16'd2;
                    r.m_cycles = 3'd2;
                end
            end
            FN_SCF: r.carry_out = 1'b1;
            FN_CCF: r.carry_out = !it.flag_carry;
            FN_DI:  ime_flag = 1'b0;
            FN_EI:  ime_flag = 1'b1;
            FN_RET, FN_RETI: begin
                r.pc_out   = stk16;
                r.sp_out   = it.sp_in + 16'd2;
                r.taken    = 1'b1;
                r.m_cycles = 3'd4;
                if (it.func == FN_RETI) ime_flag = 1'b1;
            end
            FN_RET_CC: begin
                if (cc_ok) begin
                    r.pc_out   = stk16;
                    r.sp_out   = it.sp_in + 16'd2;
                    r.taken    = 1'b1;
                    r.m_cycles = 3'd5;
                end else begin
                    r.m_cycles = 3'd2;
                end
            end
            FN_CALL_NN: begin
                if (cc_ok) begin
                    r.push_valid = 1'b1;
                    r.push_high  = ret_addr[15:8];
                    r.push_low   = ret_addr[7:0];
                    r.sp_out     = it.sp_in - 16'd2;
                    r.pc_out     = imm16;
                    r.taken      = 1'b1;
                    r.m_cycles   = 3'd6;
                end else begin
                    r.pc_out   = it.pc_in + 16'd3;
                    r.m_cycles = 3'd3;
                end
            end
            default: ;  // unused codes act as one-byte no-ops
        endcase
        r.ime_out = ime_flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ime_flag   = 1'b0;
            halt_armed = 1'b0;
            predicted_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_q.size() == 0) begin
                    report($sformatf("result %0d arrived with no request outstanding", rsp_idx));
                end else begin
                    want = predicted_q.pop_front();
                    check_field("status", 16'(i_rsp.status), 16'(want.status));
                    check_field("taken", 16'(i_rsp.taken), 16'(want.taken));
                    check_field("pc_out", i_rsp.pc_out, want.pc_out);
                    check_field("sp_out", i_rsp.sp_out, want.sp_out);
                    check_field("ime_out", 16'(i_rsp.ime_out), 16'(want.ime_out));
                    check_field("carry_out", 16'(i_rsp.carry_out), 16'(want.carry_out));
                    check_field("push_valid", 16'(i_rsp.push_valid), 16'(want.push_valid));
                    check_field("push_high", 16'(i_rsp.push_high), 16'(want.push_high));
                    check_field("push_low", 16'(i_rsp.push_low), 16'(want.push_low));
                    check_field("m_cycles", 16'(i_rsp.m_cycles), 16'(want.m_cycles));
                end
                rsp_idx++;
            end
            if (i_in_valid && !i_in_stall) begin
                predicted_q.push_back(exec_control_flow(i_req));
            end
        end
        o_pending <= predicted_q.size();
    end

endmodule

// ===== verif/tb_cpu_control_flow_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_control_flow_unit
// Drives decoded control-flow instructions into the execute unit: a short
// directed set for halt, branches, stack wrap and flag ops, then random
// instruction streams with halt runs and IME toggles, under three patterns
// of sender gaps and receiver stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_cpu_control_flow_unit;
    import cfu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    // codes outside the decoded set
    localparam logic [2:0] CC_NEVER_LO = 3'd5;
    localparam logic [2:0] CC_NEVER_HI = 3'd7;
    localparam logic [3:0] FN_NOP_LO   = 4'd13;
    localparam logic [3:0] FN_NOP_HI   = 4'd15;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  out_stall = 1'b0;
    t_item req = '0;
    logic  in_stall;
    logic  out_valid;
    logic [1:0]  status;
    logic        taken;
    logic [15:0] pc_out;
    logic [15:0] sp_out;
    logic        ime_out;
    logic        carry_out;
    logic        push_valid;
    logic [7:0]  push_high;
    logic [7:0]  push_low;
    logic [2:0]  m_cycles;
    int fail_count;
    int pending;
    int send_idle_pct = 36;
    int recv_stall_pct = 46;
    int cycle_cnt = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cpu_control_flow_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_func        (req.func),
        .i_cond        (req.cond),
        .i_flag_zero   (req.flag_zero),
        .i_flag_carry  (req.flag_carry),
        .i_pc_in       (req.pc_in),
        .i_sp_in       (req.sp_in),
        .i_hl_value    (req.hl_value),
        .i_imm_low     (req.imm_low),
        .i_imm_high    (req.imm_high),
        .i_stack_low   (req.stack_low),
        .i_stack_high  (req.stack_high),
        .i_irq_pending (req.irq_pending),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_taken       (taken),
        .o_pc_out      (pc_out),
        .o_sp_out      (sp_out),
        .o_ime_out     (ime_out),
        .o_carry_out   (carry_out),
        .o_push_valid  (push_valid),
        .o_push_high   (push_high),
        .o_push_low    (push_low),
        .o_m_cycles    (m_cycles)
    );

    cfu_flow_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_req        (req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_rsp        ({status, taken, pc_out, sp_out, ime_out, carry_out,
                        push_valid, push_high, push_low, m_cycles}),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("** cpu_control_flow_unit: FAILED **");
        $finish;
    end

    // addresses lean toward the wrap points now and then
    function automatic logic [15:0] rand_addr();
        case ($urandom_range(9))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2:       return 16'hFFFE;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.func        = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 13))
                                                  : 4'($urandom_range(12, 0));
        it.cond        = ($urandom_range(99) < 10) ? 3'($urandom_range(7, 5))
                                                   : 3'($urandom_range(4, 0));
        it.flag_zero   = 1'($urandom_range(1));
        it.flag_carry  = 1'($urandom_range(1));
        it.pc_in       = rand_addr();
        it.sp_in       = rand_addr();
        it.hl_value    = rand_addr();
        it.imm_low     = 8'($urandom_range(255));
        it.imm_high    = 8'($urandom_range(255));
        it.stack_low   = 8'($urandom_range(255));
        it.stack_high  = 8'($urandom_range(255));
        it.irq_pending = 1'($urandom_range(1));
        return it;
    endfunction

    // in_valid is lowered only in a gap, so it never toggles twice in one step
    task automatic send(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req      <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_op(logic [3:0] fn, logic [2:0] cc, logic z, logic c);
        t_item it;
        it            = rand_item();
        it.func       = fn;
        it.cond       = cc;
        it.flag_zero  = z;
        it.flag_carry = c;
        send(it);
    endtask

    task automatic run_random(int n_items);
        t_item it;
        int    sent;
        int    run_len;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0, 1: begin
                    // halt run: waits, then maybe an interrupt wakes it
                    run_len = $urandom_range(4, 1);
                    for (int j = 0; j < run_len; j++) begin
                        it = rand_item();
                        it.func = FN_HALT;
                        it.irq_pending = (j == run_len - 1) ? 1'($urandom_range(1))
                                                            : ($urandom_range(3) == 0);
                        send(it);
                    end
                    sent += run_len;
                end
                2: begin
                    it = rand_item();
                    case ($urandom_range(2))
                        0:       it.func = FN_EI;
                        1:       it.func = FN_DI;
                        default: it.func = FN_RETI;
                    endcase
                    send(it);
                    sent++;
                end
                default: begin
                    send(rand_item());
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        t_item it;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // halt without IME: waits, keeps waiting, then wakes
        it = rand_item();
        it.func = FN_HALT;
        it.irq_pending = 1'b0;
        send(it);
        send(it);
        it.irq_pending = 1'b1;
        send(it);
        // interrupt already pending: one wasted request, then done
        send(it);
        send(it);
        send_op(FN_STOP, CC_ALWAYS, 1'b0, 1'b0);
        it = rand_item();
        it.func = FN_JP_HL;
        it.hl_value = 16'hFFFF;
        send(it);
        send_op(FN_JP_NN, CC_Z, 1'b0, 1'b1);
        send_op(FN_JP_NN, CC_C, 1'b1, 1'b1);
        send_op(FN_JP_NN, CC_NEVER_HI, 1'b1, 1'b1);
        // relative jumps across both wrap points
        it = rand_item();
        it.func = FN_JR_N;
        it.cond = CC_NZ;
        it.flag_zero = 1'b0;
        it.pc_in = 16'h0001;
        it.imm_low = 8'h80;
        send(it);
        it.cond = CC_ALWAYS;
        it.pc_in = 16'hFFFF;
        it.imm_low = 8'h7F;
        send(it);
        it.cond = CC_NC;
        it.flag_carry = 1'b1;
        send(it);
        send_op(FN_SCF, CC_ALWAYS, 1'b0, 1'b0);
        send_op(FN_CCF, CC_ALWAYS, 1'b0, 1'b1);
        send_op(FN_CCF, CC_ALWAYS, 1'b1, 1'b0);
        // halt with IME set
        send_op(FN_EI, CC_ALWAYS, 1'b0, 1'b0);
        send_op(FN_HALT, CC_ALWAYS, 1'b0, 1'b0);
        send_op(FN_DI, CC_ALWAYS, 1'b0, 1'b0);
        it = rand_item();
        it.func = FN_RET;
        it.sp_in = 16'hFFFF;
        send(it);
        it.func = FN_RETI;
        it.sp_in = 16'hFFFE;
        send(it);
        send_op(FN_RET_CC, CC_Z, 1'b1, 1'b0);
        send_op(FN_RET_CC, CC_NEVER_LO, 1'b0, 1'b0);
        // call pushing a wrapped return address onto a wrapped stack
        it = rand_item();
        it.func = FN_CALL_NN;
        it.cond = CC_ALWAYS;
        it.pc_in = 16'hFFFE;
        it.sp_in = 16'h0001;
        send(it);
        send_op(FN_CALL_NN, CC_NC, 1'b0, 1'b1);
        send_op(FN_NOP_LO, CC_ALWAYS, 1'b0, 1'b0);
        send_op(FN_NOP_HI, CC_ALWAYS, 1'b0, 1'b0);

        run_random(130);
        drain();
        send_idle_pct  = 46;
        recv_stall_pct = 36;
        run_random(130);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(140);
        drain();
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("** cpu_control_flow_unit: PASSED **");
        end else begin
            $display("** cpu_control_flow_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== cpu_control_flow_unit.f =====
design/cfu_pkg.sv
design/cfu_exec.sv
design/cpu_control_flow_unit.sv
verif/cfu_flow_checker.sv
verif/tb_cpu_control_flow_unit.sv
